// ===== sv/eggdrop_pkg.sv =====
// types, constants and microcode table for the egg drop minimum trials block
`default_nettype none

package eggdrop_pkg;

   localparam int EGG_W   = 7;
   localparam int FLOOR_W = 11;
   localparam int DROP_W  = 11;
   localparam int CNT_W   = FLOOR_W + 1;

   // sequencer steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_INIT  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_EGG   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ROW1  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_FCHK  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LOOP  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DRAIN = 4'd6;
   localparam logic [STEP_W-1:0] STEP_WRITE = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SWAP  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_FIN   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_OUT   = 4'd10;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
   localparam logic [COND_W-1:0] COND_REQ      = 3'd1;
   localparam logic [COND_W-1:0] COND_F_END    = 3'd2;
   localparam logic [COND_W-1:0] COND_E_END    = 3'd3;
   localparam logic [COND_W-1:0] COND_F_OVER   = 3'd4;
   localparam logic [COND_W-1:0] COND_X_END    = 3'd5;
   localparam logic [COND_W-1:0] COND_STABLE   = 3'd6;
   localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd7;

   // row memory write operations
   localparam int WR_W = 3;
   localparam logic [WR_W-1:0] WR_NONE = 3'd0;
   localparam logic [WR_W-1:0] WR_INIT = 3'd1;
   localparam logic [WR_W-1:0] WR_ZERO = 3'd2;
   localparam logic [WR_W-1:0] WR_ONE  = 3'd3;
   localparam logic [WR_W-1:0] WR_BEST = 3'd4;

   // counter operations
   localparam logic [1:0] F_HOLD = 2'd0;
   localparam logic [1:0] F_ZERO = 2'd1;
   localparam logic [1:0] F_TWO  = 2'd2;
   localparam logic [1:0] F_INC  = 2'd3;

   localparam logic [1:0] E_HOLD = 2'd0;
   localparam logic [1:0] E_ONE  = 2'd1;
   localparam logic [1:0] E_INC  = 2'd2;

   localparam logic [1:0] X_HOLD = 2'd0;
   localparam logic [1:0] X_ONE  = 2'd1;
   localparam logic [1:0] X_INC  = 2'd2;

   // row memory read operations
   localparam logic [1:0] RD_NONE      = 2'd0;
   localparam logic [1:0] RD_LOOP      = 2'd1;
   localparam logic [1:0] RD_LOWER_F   = 2'd2;
   localparam logic [1:0] RD_LOWER_TOP = 2'd3;

   typedef struct packed {
      logic            ld_req;
      logic [WR_W-1:0] wr_op;
      logic [1:0]      f_op;
      logic [1:0]      e_op;
      logic [1:0]      x_op;
      logic [1:0]      rd_op;
      logic            best_init;
      logic            acc;
      logic            stable_set;
      logic            stable_cmp;
      logic            sel_flip;
      logic            out_cap;
   } ctrl_type;

   typedef struct packed {
      logic f_end;
      logic e_end;
      logic f_over;
      logic x_end;
      logic stable;
   } dp_flags_type;

   typedef struct packed {
      logic         req_acc;
      logic         out_free;
      dp_flags_type dp;
   } status_type;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] tgt;
      logic [STEP_W-1:0] nxt;
      ctrl_type          ctrl;
   } uword_type;

   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.cond = COND_REQ;  w.tgt = STEP_INIT;  w.nxt = STEP_IDLE;
            w.ctrl.ld_req = 1'b1;
            w.ctrl.f_op   = F_ZERO;
            w.ctrl.e_op   = E_ONE;
         end
         STEP_INIT: begin
            w.cond = COND_F_END;  w.tgt = STEP_EGG;  w.nxt = STEP_INIT;
            w.ctrl.wr_op = WR_INIT;
            w.ctrl.f_op  = F_INC;
         end
         STEP_EGG: begin
            w.cond = COND_E_END;  w.tgt = STEP_FIN;  w.nxt = STEP_ROW1;
            w.ctrl.e_op       = E_INC;
            w.ctrl.wr_op      = WR_ZERO;
            w.ctrl.stable_set = 1'b1;
         end
         STEP_ROW1: begin
            w.cond = COND_ALWAYS;  w.tgt = STEP_FCHK;  w.nxt = STEP_FCHK;
            w.ctrl.wr_op = WR_ONE;
            w.ctrl.f_op  = F_TWO;
         end
         STEP_FCHK: begin
            w.cond = COND_F_OVER;  w.tgt = STEP_SWAP;  w.nxt = STEP_LOOP;
            w.ctrl.x_op      = X_ONE;
            w.ctrl.best_init = 1'b1;
         end
         STEP_LOOP: begin
            w.cond = COND_X_END;  w.tgt = STEP_DRAIN;  w.nxt = STEP_LOOP;
            w.ctrl.rd_op = RD_LOOP;
            w.ctrl.acc   = 1'b1;
            w.ctrl.x_op  = X_INC;
         end
         STEP_DRAIN: begin
            w.cond = COND_ALWAYS;  w.tgt = STEP_WRITE;  w.nxt = STEP_WRITE;
            w.ctrl.acc   = 1'b1;
            w.ctrl.rd_op = RD_LOWER_F;
         end
         STEP_WRITE: begin
            w.cond = COND_ALWAYS;  w.tgt = STEP_FCHK;  w.nxt = STEP_FCHK;
            w.ctrl.wr_op      = WR_BEST;
            w.ctrl.stable_cmp = 1'b1;
            w.ctrl.f_op       = F_INC;
         end
         STEP_SWAP: begin
            w.cond = COND_STABLE;  w.tgt = STEP_FIN;  w.nxt = STEP_EGG;
            w.ctrl.sel_flip = 1'b1;
         end
         STEP_FIN: begin
            w.cond = COND_ALWAYS;  w.tgt = STEP_OUT;  w.nxt = STEP_OUT;
            w.ctrl.rd_op = RD_LOWER_TOP;
         end
         STEP_OUT: begin
            w.cond = COND_OUT_FREE;  w.tgt = STEP_IDLE;  w.nxt = STEP_OUT;
            w.ctrl.rd_op   = RD_LOWER_TOP;
            w.ctrl.out_cap = 1'b1;
         end
         default: begin
            w.cond = COND_ALWAYS;  w.tgt = STEP_IDLE;  w.nxt = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== sv/eggdrop_ram.sv =====
// single write port, single registered read port row memory
`default_nettype none

module eggdrop_ram #(
   parameter int DEPTH = 2,
   parameter int AW    = 1,
   parameter int DW    = 1
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/eggdrop_seq.sv =====
// microcode sequencer: step counter, control table lookup and conditional jumps
`default_nettype none

module eggdrop_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  eggdrop_pkg::status_type status,
   output eggdrop_pkg::ctrl_type   ctrl
);

   import eggdrop_pkg::*;

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   uword_type         uw;
   logic              take;

   always_comb begin
      uw = ucode_rom(pc_ff);
      unique case (uw.cond)
         COND_ALWAYS:   take = 1'b1;
         COND_REQ:      take = status.req_acc;
         COND_F_END:    take = status.dp.f_end;
         COND_E_END:    take = status.dp.e_end;
         COND_F_OVER:   take = status.dp.f_over;
         COND_X_END:    take = status.dp.x_end;
         COND_STABLE:   take = status.dp.stable;
         COND_OUT_FREE: take = status.out_free;
      endcase
      pc_in = take ? uw.tgt : uw.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = uw.ctrl;

endmodule

`default_nettype wire

// ===== sv/eggdrop_dp.sv =====
// datapath: counters, min/max unit and the two ping-pong row memories
`default_nettype none

module eggdrop_dp #(
   parameter int MAX_EGG_COUNT   = 64,
   parameter int MAX_FLOOR_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  eggdrop_pkg::ctrl_type               ctrl,
   input  logic [eggdrop_pkg::EGG_W-1:0]       req_egg_count,
   input  logic [eggdrop_pkg::FLOOR_W-1:0]     req_floor_count,
   output eggdrop_pkg::dp_flags_type           flags,
   output logic [eggdrop_pkg::DROP_W-1:0]      result
);

   import eggdrop_pkg::*;

   localparam int EGGC_W  = $clog2(MAX_EGG_COUNT + 1);
   localparam int EWIDE_W = EGGC_W + EGG_W;
   localparam int DEPTH   = MAX_FLOOR_COUNT + 1;
   localparam int AW      = $clog2(DEPTH);
   localparam int FWIDE_W = AW + FLOOR_W;

   logic [EWIDE_W-1:0] egg_wide;
   logic [FWIDE_W-1:0] floor_wide;
   logic [EGGC_W-1:0]  eggs_ff, eggs_in, e_ff, e_in;
   logic [FLOOR_W-1:0] floors_ff, floors_in;
   logic [CNT_W-1:0]   f_ff, f_in;
   logic [FLOOR_W-1:0] x_ff, x_in;
   logic [DROP_W-1:0]  best_ff, best_in;
   logic               stable_ff, stable_in;
   logic               sel_ff, sel_in;
   logic               pend_ff, pend_in;

   logic [FLOOR_W-1:0] lo_raddr, th_raddr, waddr;
   logic [DROP_W-1:0]  wdata;
   logic               wr_en, wr_lower;
   logic [AW-1:0]      raddr0, raddr1, waddr_a;
   logic               we0, we1;
   logic [DROP_W-1:0]  rd0, rd1, lower_q, this_q;
   logic [DROP_W:0]    worst;

   // request clamping
   always_comb begin
      egg_wide   = EWIDE_W'(req_egg_count);
      floor_wide = FWIDE_W'(req_floor_count);
      if (egg_wide == '0) begin
         eggs_in = EGGC_W'(1);
      end else if (egg_wide > EWIDE_W'(MAX_EGG_COUNT)) begin
         eggs_in = EGGC_W'(MAX_EGG_COUNT);
      end else begin
         eggs_in = EGGC_W'(egg_wide);
      end
      if (floor_wide > FWIDE_W'(MAX_FLOOR_COUNT)) begin
         floors_in = FLOOR_W'(MAX_FLOOR_COUNT);
      end else begin
         floors_in = FLOOR_W'(floor_wide);
      end
   end

   // counters
   always_comb begin
      unique case (ctrl.f_op)
         F_HOLD: f_in = f_ff;
         F_ZERO: f_in = '0;
         F_TWO:  f_in = CNT_W'(2);
         F_INC:  f_in = f_ff + CNT_W'(1);
      endcase
      unique case (ctrl.e_op)
         E_ONE:   e_in = EGGC_W'(1);
         E_INC:   e_in = e_ff + EGGC_W'(1);
         E_HOLD:  e_in = e_ff;
         default: e_in = e_ff;
      endcase
      unique case (ctrl.x_op)
         X_ONE:   x_in = FLOOR_W'(1);
         X_INC:   x_in = x_ff + FLOOR_W'(1);
         X_HOLD:  x_in = x_ff;
         default: x_in = x_ff;
      endcase
   end

   // memory addressing
   always_comb begin
      unique case (ctrl.rd_op)
         RD_LOOP:      lo_raddr = x_ff - FLOOR_W'(1);
         RD_LOWER_F:   lo_raddr = f_ff[FLOOR_W-1:0];
         RD_LOWER_TOP: lo_raddr = floors_ff;
         RD_NONE:      lo_raddr = '0;
      endcase
      th_raddr = f_ff[FLOOR_W-1:0] - x_ff;

      wr_en    = 1'b1;
      wr_lower = 1'b0;
      unique case (ctrl.wr_op)
         WR_INIT: begin
            wr_lower = 1'b1;
            waddr    = f_ff[FLOOR_W-1:0];
            wdata    = DROP_W'(f_ff[FLOOR_W-1:0]);
         end
         WR_ZERO: begin
            waddr = '0;
            wdata = '0;
         end
         WR_ONE: begin
            waddr = FLOOR_W'(1);
            wdata = DROP_W'(1);
         end
         WR_BEST: begin
            waddr = f_ff[FLOOR_W-1:0];
            wdata = best_ff;
         end
         WR_NONE: begin
            wr_en = 1'b0;
            waddr = '0;
            wdata = '0;
         end
         default: begin
            wr_en = 1'b0;
            waddr = '0;
            wdata = '0;
         end
      endcase

      // bank sel_ff holds the lower egg row
      raddr0  = AW'(sel_ff ? th_raddr : lo_raddr);
      raddr1  = AW'(sel_ff ? lo_raddr : th_raddr);
      waddr_a = AW'(waddr);
      we0     = wr_en & (wr_lower == !sel_ff);
      we1     = wr_en & (wr_lower == sel_ff);
      lower_q = sel_ff ? rd1 : rd0;
      this_q  = sel_ff ? rd0 : rd1;
   end

   // candidate drop floor evaluation
   always_comb begin
      worst = ((lower_q > this_q) ? {1'b0, lower_q} : {1'b0, this_q}) + (DROP_W + 1)'(1);
      if (ctrl.best_init) begin
         best_in = DROP_W'(floors_ff);
      end else if (ctrl.acc && pend_ff && (worst < {1'b0, best_ff})) begin
         best_in = worst[DROP_W-1:0];
      end else begin
         best_in = best_ff;
      end

      if (ctrl.stable_set) begin
         stable_in = 1'b1;
      end else if (ctrl.stable_cmp && (lower_q != best_ff)) begin
         stable_in = 1'b0;
      end else begin
         stable_in = stable_ff;
      end

      if (ctrl.ld_req) begin
         sel_in = 1'b0;
      end else if (ctrl.sel_flip) begin
         sel_in = ~sel_ff;
      end else begin
         sel_in = sel_ff;
      end

      pend_in = (ctrl.rd_op == RD_LOOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         stable_ff <= 1'b0;
      end else begin
         sel_ff    <= sel_in;
         pend_ff   <= pend_in;
         stable_ff <= stable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_req) begin
         eggs_ff   <= eggs_in;
         floors_ff <= floors_in;
      end
      e_ff    <= e_in;
      f_ff    <= f_in;
      x_ff    <= x_in;
      best_ff <= best_in;
   end

   eggdrop_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DROP_W)
   ) u_bank0 (
      .clock   (clock),
      .we      (we0),
      .waddr   (waddr_a),
      .wdata   (wdata),
      .raddr   (raddr0),
      .rd_data (rd0)
   );

   eggdrop_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DROP_W)
   ) u_bank1 (
      .clock   (clock),
      .we      (we1),
      .waddr   (waddr_a),
      .wdata   (wdata),
      .raddr   (raddr1),
      .rd_data (rd1)
   );

   assign flags.f_end  = (f_ff == CNT_W'(floors_ff));
   assign flags.f_over = (f_ff > CNT_W'(floors_ff));
   assign flags.e_end  = (e_ff >= eggs_ff);
   assign flags.x_end  = (x_ff == f_ff[FLOOR_W-1:0]);
   assign flags.stable = stable_ff;
   assign result       = lower_q;

endmodule

`default_nettype wire

// ===== sv/egg_drop_min_trials_top.sv =====
// top level of the egg drop minimum trials block
//
//   channel | ports                                   | direction
//   req     | req_valid req_ready req_egg_count      | in
//           | req_floor_count                         |
//   rsp     | rsp_valid rsp_ready rsp_min_drops       | out
//
// egg rows built: the clamped egg count minus one, fewer once a row repeats the one below
// the inner loop tries one drop floor per cycle, bound by the single read port
// of each row memory
// reset clears the step counter and the output valid flag; no memory clearing pass
// a new item is taken while a finished result waits in the output register
`default_nettype none

module egg_drop_min_trials_top #(
   parameter int MAX_EGG_COUNT   = 64,
   parameter int MAX_FLOOR_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [eggdrop_pkg::EGG_W-1:0]       req_egg_count,
   input  logic [eggdrop_pkg::FLOOR_W-1:0]     req_floor_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [eggdrop_pkg::DROP_W-1:0]      rsp_min_drops
);

   import eggdrop_pkg::*;

   ctrl_type          ctrl;
   status_type        status;
   dp_flags_type      flags;
   logic [DROP_W-1:0] result;
   logic              out_free;
   logic              capture;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DROP_W-1:0] rsp_min_drops_ff, rsp_min_drops_in;

   eggdrop_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   eggdrop_dp #(
      .MAX_EGG_COUNT   (MAX_EGG_COUNT),
      .MAX_FLOOR_COUNT (MAX_FLOOR_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_egg_count   (req_egg_count),
      .req_floor_count (req_floor_count),
      .flags           (flags),
      .result          (result)
   );

   always_comb begin
      out_free        = !rsp_valid_ff || rsp_ready;
      capture         = ctrl.out_cap && out_free;
      status.req_acc  = req_valid && ctrl.ld_req;
      status.out_free = out_free;
      status.dp       = flags;

      if (capture) begin
         rsp_valid_in     = 1'b1;
         rsp_min_drops_in = result;
      end else begin
         rsp_valid_in     = rsp_valid_ff && !rsp_ready;
         rsp_min_drops_in = rsp_min_drops_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_min_drops_ff <= rsp_min_drops_in;
   end

   assign req_ready     = ctrl.ld_req;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_drops = rsp_min_drops_ff;

   // an accepted item moves the sequencer out of its idle step
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a result only appears from the output step of the program
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.out_cap))
      else $error("result raised outside output step");

   // a waiting result is not overwritten by the next item
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.out_cap && rsp_valid_ff && !rsp_ready) |=> $stable(rsp_min_drops_ff))
      else $error("pending result overwritten");

   // the idle step and the output step never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(ctrl.ld_req && ctrl.out_cap))
      else $error("idle and output steps overlap");

endmodule

`default_nettype wire
